[hdl/avcab_pkg.sv]
`default_nettype none

package avcab_pkg;

   // Width of the byte position counter and of the tag length input
   localparam int TAG_LENGTH_BITS = 24;

   // Wide enough for 9 + 32-bit NALU length and every header sum
   localparam int CMP_BITS = 34;

   // Action queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // AVC packet types
   localparam logic [7:0] PKT_SEQ_HEADER = 8'd0;
   localparam logic [7:0] PKT_NALU       = 8'd1;

   // Start code 00 00 00 01
   localparam logic [7:0] START_ZERO_BYTE = 8'h00;
   localparam logic [7:0] START_LAST_BYTE = 8'h01;

   // Result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_IGNORED       = 3'd1,
      STATUS_SPS_OVERRUN   = 3'd2,
      STATUS_PPS_MISMATCH  = 3'd3,
      STATUS_NALU_MISMATCH = 3'd4,
      STATUS_TRUNCATED     = 3'd5
   } status_type;

   // What one input byte asks the back end to emit, in this order:
   // start code, data byte, closing status
   typedef struct packed {
      logic       start;
      logic       data_en;
      logic [7:0] data;
      logic       close;
      status_type status;
   } action_type;

endpackage

`default_nettype wire

[hdl/avcab_front.sv]
`default_nettype none

module avcab_front
   import avcab_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [7:0]                 data_byte,
   input  wire logic [TAG_LENGTH_BITS-1:0] tag_length,
   input  wire logic                       end_of_tag,
   output      logic                       push,
   output      action_type                 act
);

   logic [TAG_LENGTH_BITS-1:0] pos_ff,  pos_in;
   logic [7:0]                 pt_ff,   pt_in;
   logic [15:0]                sps_ff,  sps_in;
   logic [15:0]                pps_ff,  pps_in;
   logic [31:0]                nalu_ff, nalu_in;
   status_type                 err_ff,  err_in;

   logic [15:0]         sps_new, pps_new;
   logic [31:0]         nalu_new;
   logic [CMP_BITS-1:0] p_x, len_x, s_x, pps_x, count_x;

   always_comb begin
      sps_new  = sps_ff | {8'h00, data_byte};
      pps_new  = pps_ff | {8'h00, data_byte};
      nalu_new = {nalu_ff[23:0], data_byte};
      p_x      = CMP_BITS'(pos_ff);
      len_x    = CMP_BITS'(tag_length);
      s_x      = CMP_BITS'(sps_ff);
      pps_x    = CMP_BITS'(pps_ff);
      count_x  = p_x + CMP_BITS'(1);
   end

   always_comb begin
      pos_in      = pos_ff;
      pt_in       = pt_ff;
      sps_in      = sps_ff;
      pps_in      = pps_ff;
      nalu_in     = nalu_ff;
      err_in      = err_ff;
      act.start   = 1'b0;
      act.data_en = 1'b0;
      act.data    = data_byte;
      act.close   = 1'b0;
      act.status  = STATUS_OK;

      if (accept) begin
         if (p_x == CMP_BITS'(1)) begin
            pt_in = data_byte;
         end else if (p_x >= CMP_BITS'(2) && err_ff == STATUS_OK) begin
            if (pt_ff == PKT_SEQ_HEADER) begin
               if (p_x == CMP_BITS'(11)) begin
                  sps_in = {data_byte, 8'h00};
               end else if (p_x == CMP_BITS'(12)) begin
                  sps_in = sps_new;
                  if (CMP_BITS'(16) + CMP_BITS'(sps_new) > len_x) begin
                     err_in = STATUS_SPS_OVERRUN;
                  end else begin
                     act.start = 1'b1;
                  end
               end else if (p_x >= CMP_BITS'(13)) begin
                  if (p_x < CMP_BITS'(13) + s_x) begin
                     act.data_en = (p_x < len_x);
                  end else if (p_x == CMP_BITS'(14) + s_x) begin
                     pps_in = {data_byte, 8'h00};
                  end else if (p_x == CMP_BITS'(15) + s_x) begin
                     pps_in = pps_new;
                     if (CMP_BITS'(16) + s_x + CMP_BITS'(pps_new) != len_x) begin
                        err_in = STATUS_PPS_MISMATCH;
                     end else begin
                        act.start = 1'b1;
                     end
                  end else if (p_x >= CMP_BITS'(16) + s_x) begin
                     act.data_en = (p_x < CMP_BITS'(16) + s_x + pps_x) && (p_x < len_x);
                  end
               end
            end else if (pt_ff == PKT_NALU) begin
               if (p_x >= CMP_BITS'(5) && p_x <= CMP_BITS'(8)) begin
                  nalu_in = nalu_new;
                  if (p_x == CMP_BITS'(8)) begin
                     if (CMP_BITS'(9) + CMP_BITS'(nalu_new) != len_x) begin
                        err_in = STATUS_NALU_MISMATCH;
                     end else begin
                        act.start = 1'b1;
                     end
                  end
               end else if (p_x >= CMP_BITS'(9)) begin
                  act.data_en = (p_x < len_x);
               end
            end
         end

         if (end_of_tag) begin
            act.close = 1'b1;
            // status sees the error and packet type as updated by this byte
            if (err_in != STATUS_OK) begin
               act.status = err_in;
            end else if (count_x != len_x || count_x < CMP_BITS'(2)) begin
               act.status = STATUS_TRUNCATED;
            end else if (pt_in == PKT_SEQ_HEADER) begin
               act.status = (count_x < CMP_BITS'(13)) ? STATUS_TRUNCATED : STATUS_OK;
            end else if (pt_in == PKT_NALU) begin
               act.status = (count_x < CMP_BITS'(9)) ? STATUS_TRUNCATED : STATUS_OK;
            end else begin
               act.status = STATUS_IGNORED;
            end
            pos_in  = '0;
            pt_in   = '0;
            sps_in  = '0;
            pps_in  = '0;
            nalu_in = '0;
            err_in  = STATUS_OK;
         end else if (pos_ff != {TAG_LENGTH_BITS{1'b1}}) begin
            pos_in = pos_ff + TAG_LENGTH_BITS'(1);
         end
      end
   end

   assign push = accept && (act.start || act.data_en || act.close);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pt_ff   <= '0;
         sps_ff  <= '0;
         pps_ff  <= '0;
         nalu_ff <= '0;
         err_ff  <= STATUS_OK;
      end else begin
         pos_ff  <= pos_in;
         pt_ff   <= pt_in;
         sps_ff  <= sps_in;
         pps_ff  <= pps_in;
         nalu_ff <= nalu_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

[hdl/avcab_queue.sv]
`default_nettype none

module avcab_queue
   import avcab_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire action_type  push_act,
   input  wire logic        pop,
   output      action_type  head,
   output      logic        not_empty,
   output      logic        full
);

   action_type                  store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ff, wr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ff, rd_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign head      = store_ff[rd_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/avcab_back.sv]
`default_nettype none

module avcab_back
   import avcab_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire action_type head,
   input  wire logic       head_valid,
   output      logic       pop,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_kind,
   output      logic [7:0] rsp_out_byte,
   output      logic [2:0] rsp_status,
   output      logic       rsp_last
);

   logic [2:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic       kind_ff,  kind_in;
   logic [7:0] byte_ff,  byte_in;
   logic [2:0] status_ff, status_in;
   logic       last_ff,  last_in;
   logic       load, data_phase;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      data_phase = head.start ? (phase_ff < 3'd4) : (head.data_en && phase_ff == 3'd0);

      if (head.start) begin
         last_in = head.close ? (phase_ff == 3'd4) : (phase_ff == 3'd3);
      end else if (head.data_en) begin
         last_in = head.close ? (phase_ff == 3'd1) : (phase_ff == 3'd0);
      end else begin
         last_in = 1'b1;
      end

      if (data_phase) begin
         kind_in   = KIND_DATA;
         status_in = STATUS_OK;
         if (head.start) begin
            byte_in = (phase_ff == 3'd3) ? START_LAST_BYTE : START_ZERO_BYTE;
         end else begin
            byte_in = head.data;
         end
      end else begin
         kind_in   = KIND_CLOSE;
         byte_in   = 8'h00;
         status_in = head.status;
      end

      valid_in = valid_ff;
      phase_in = phase_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            pop      = last_in;
            phase_in = last_in ? 3'd0 : phase_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

[hdl/flv_avc_tag_to_annexb.sv]
// FLV AVC video tag to H.264 Annex-B converter. Feed the tag payload one byte per
// transfer with its tag length and an end-of-tag mark on the final byte. A sequence
// header (packet type 0) comes out as start code 00 00 00 01, SPS, start code, PPS;
// a NALU packet (type 1) as a start code and the NALU payload. Bytes stream out as
// they arrive, so a tag that fails a length check may already have produced output:
// every tag ends with one closing-status result (kind 1) telling downstream to
// commit (status 0) or drop (1 ignored type, 2 SPS overrun, 3 SPS/PPS mismatch,
// 4 NALU mismatch, 5 truncated) everything emitted for that tag. The last flag
// marks the final result caused by each input byte; a byte that causes nothing
// produces no transfer. Rate: the front end takes one byte per cycle unless the
// queue is full; the back end emits one result per cycle unless rsp_stall is
// high, so a byte costs one result, a start code four and a closing status one
// more. A four-entry action queue between them absorbs start-code bursts; input
// stalls only when it fills. The back end drives the results from registers.
`default_nettype none

module flv_avc_tag_to_annexb
   import avcab_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [23:0] req_tag_length,
   input  wire logic        req_end_of_tag,
   // result output
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_kind,
   output      logic [7:0]  rsp_out_byte,
   output      logic [2:0]  rsp_status,
   output      logic        rsp_last
);

   logic       accept;
   logic       push, pop;
   logic       head_valid, queue_full;
   action_type act, head;

   // input stalls only on a full queue, never on the output side directly
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // front: tracks position in the tag, parses lengths, decides what to emit
   avcab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .tag_length (req_tag_length[TAG_LENGTH_BITS-1:0]),
      .end_of_tag (req_end_of_tag),
      .push       (push),
      .act        (act)
   );

   // actions waiting for the back end
   avcab_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_act  (act),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   // back: expands each action into result transfers via a registered output
   avcab_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire
